// ===== rtl/core/opl_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered pin list package
// Sizes, command codes, cell operations and shared types of the pin list.
// ----------------------------------------------------------------------------
package opl_pkg;

  localparam int MaxPins = 32;
  localparam int IdxW    = (MaxPins > 1) ? $clog2(MaxPins) : 1;
  localparam int CntW    = $clog2(MaxPins + 1);
  localparam int CoordW  = 16;
  localparam int CmdW    = 8;
  localparam int PosW    = 8;

  localparam logic [CmdW-1:0] CmdAppend = 8'd1;
  localparam logic [CmdW-1:0] CmdInsert = 8'd2;
  localparam logic [CmdW-1:0] CmdMove   = 8'd3;
  localparam logic [CmdW-1:0] CmdDelete = 8'd4;
  localparam logic [CmdW-1:0] CmdClear  = 8'd5;

  // Operations that every cell of the chain applies in the same cycle.
  localparam logic [2:0] OpHold   = 3'd0;
  localparam logic [2:0] OpInsert = 3'd1;
  localparam logic [2:0] OpDelete = 3'd2;
  localparam logic [2:0] OpWrite  = 3'd3;
  localparam logic [2:0] OpRotate = 3'd4;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } pin_t;

  typedef struct packed {
    logic [2:0]      op;
    logic [IdxW-1:0] slot;
    pin_t            pin;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/opl_cell.sv =====
// ----------------------------------------------------------------------------
// Pin list cell
// Holds one pin and takes its own, a neighbor's or the new pin each cycle.
// ----------------------------------------------------------------------------
module opl_cell (
  input  logic                     clk_i,
  input  logic [opl_pkg::IdxW-1:0] idx_i,
  input  opl_pkg::cell_ctrl_t      ctrl_i,
  input  opl_pkg::pin_t            prev_i,
  input  opl_pkg::pin_t            next_i,
  output opl_pkg::pin_t            pin_o
);

  opl_pkg::pin_t pin_q, pin_d;

  always_comb begin
    pin_d = pin_q;
    case (ctrl_i.op)
      opl_pkg::OpInsert: begin
        // Cells behind the slot move one place toward the tail.
        if (idx_i > ctrl_i.slot) begin
          pin_d = prev_i;
        end else if (idx_i == ctrl_i.slot) begin
          pin_d = ctrl_i.pin;
        end
      end
      opl_pkg::OpDelete: begin
        if (idx_i >= ctrl_i.slot) begin
          pin_d = next_i;
        end
      end
      opl_pkg::OpWrite: begin
        if (idx_i == ctrl_i.slot) begin
          pin_d = ctrl_i.pin;
        end
      end
      opl_pkg::OpRotate: begin
        pin_d = next_i;
      end
      default: begin
        pin_d = pin_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    pin_q <= pin_d;
  end

  assign pin_o = pin_q;

endmodule

// ===== rtl/core/ordered_pin_list_engine.sv =====
// ----------------------------------------------------------------------------
// Ordered pin list engine
// Keeps an ordered list of map pins in a ring of cells and dumps it on demand.
// ----------------------------------------------------------------------------
// An edit word (append, insert, overwrite, delete, clear) is applied as it
// is accepted and busy_o stays low, so edits may follow each other in every
// cycle. A dump word raises busy_o while the ring rotates: the header word
// appears on the result ports in the cycle after the dump is accepted, then
// the ring of 32 cells rotates once toward cell 0, one place a cycle, and
// each stored pin is shown as it reaches cell 0; the rotation runs in full
// whatever the fill. Every result word is shown for exactly one cycle with
// result_valid_o high and must be taken then, as the receiver cannot stall.
module ordered_pin_list_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       req_type_i,
  input  logic [opl_pkg::CmdW-1:0]   command_code_i,
  input  logic [opl_pkg::PosW-1:0]   position_i,
  input  logic [opl_pkg::CoordW-1:0] pin_x_in_i,
  input  logic [opl_pkg::CoordW-1:0] pin_y_in_i,
  output logic                       result_valid_o,
  output logic                       record_kind_o,
  output logic [opl_pkg::CoordW-1:0] pin_x_out_o,
  output logic [opl_pkg::CoordW-1:0] pin_y_out_o,
  output logic                       last_record_o
);

  logic                     accept;
  logic                     pos_lt_cnt;
  logic [opl_pkg::CntW-1:0] count_q, count_d;
  logic                     dump_q, dump_d;
  logic [opl_pkg::IdxW-1:0] rot_q, rot_d;
  logic [opl_pkg::CntW-1:0] rot_ext;
  logic                     strobe_q, strobe_d;
  logic                     kind_q, kind_d;
  logic                     last_q, last_d;
  opl_pkg::pin_t            out_pin_q, out_pin_d;
  opl_pkg::cell_ctrl_t      ctrl;
  opl_pkg::pin_t            cell_pin [opl_pkg::MaxPins];

  assign accept     = start_i && !busy_o;
  assign pos_lt_cnt = position_i < {{(opl_pkg::PosW - opl_pkg::CntW){1'b0}}, count_q};
  assign rot_ext    = {{(opl_pkg::CntW - opl_pkg::IdxW){1'b0}}, rot_q};

  always_comb begin
    ctrl.op    = opl_pkg::OpHold;
    ctrl.slot  = count_q[opl_pkg::IdxW-1:0];
    ctrl.pin.x = pin_x_in_i;
    ctrl.pin.y = pin_y_in_i;
    count_d    = count_q;
    dump_d     = dump_q;
    rot_d      = rot_q;
    strobe_d   = 1'b0;
    kind_d     = kind_q;
    last_d     = last_q;
    out_pin_d  = out_pin_q;

    if (dump_q) begin
      // Cell 0 holds pin rot_q of the list in this cycle.
      ctrl.op   = opl_pkg::OpRotate;
      strobe_d  = rot_ext < count_q;
      kind_d    = 1'b1;
      out_pin_d = cell_pin[0];
      last_d    = (rot_ext + opl_pkg::CntW'(1)) == count_q;
      rot_d     = rot_q + opl_pkg::IdxW'(1);
      if (rot_q == opl_pkg::IdxW'(opl_pkg::MaxPins - 1)) begin
        dump_d = 1'b0;
      end
    end else if (accept && req_type_i) begin
      strobe_d    = 1'b1;
      kind_d      = 1'b0;
      out_pin_d.x = '0;
      out_pin_d.y = '0;
      last_d      = count_q == '0;
      dump_d      = 1'b1;
      rot_d       = '0;
    end else if (accept) begin
      case (command_code_i)
        opl_pkg::CmdAppend: begin
          if (count_q != opl_pkg::CntW'(opl_pkg::MaxPins)) begin
            ctrl.op = opl_pkg::OpInsert;
            count_d = count_q + opl_pkg::CntW'(1);
          end
        end
        opl_pkg::CmdInsert: begin
          // A position past the end appends the pin.
          if (count_q != opl_pkg::CntW'(opl_pkg::MaxPins)) begin
            ctrl.op = opl_pkg::OpInsert;
            if (pos_lt_cnt) begin
              ctrl.slot = position_i[opl_pkg::IdxW-1:0];
            end
            count_d = count_q + opl_pkg::CntW'(1);
          end
        end
        opl_pkg::CmdMove: begin
          if (pos_lt_cnt) begin
            ctrl.op   = opl_pkg::OpWrite;
            ctrl.slot = position_i[opl_pkg::IdxW-1:0];
          end
        end
        opl_pkg::CmdDelete: begin
          if (pos_lt_cnt) begin
            ctrl.op   = opl_pkg::OpDelete;
            ctrl.slot = position_i[opl_pkg::IdxW-1:0];
            count_d   = count_q - opl_pkg::CntW'(1);
          end
        end
        opl_pkg::CmdClear: begin
          count_d = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  // The cells form a ring: the head's predecessor is the tail and the tail's
  // successor is the head, so a full rotation restores the list.
  for (genvar i = 0; i < opl_pkg::MaxPins; i++) begin : g_cell
    opl_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (opl_pkg::IdxW'(i)),
      .ctrl_i (ctrl),
      .prev_i (cell_pin[(i + opl_pkg::MaxPins - 1) % opl_pkg::MaxPins]),
      .next_i (cell_pin[(i + 1) % opl_pkg::MaxPins]),
      .pin_o  (cell_pin[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      dump_q   <= 1'b0;
      rot_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      dump_q   <= dump_d;
      rot_q    <= rot_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    last_q    <= last_d;
    out_pin_q <= out_pin_d;
  end

  assign busy_o         = dump_q;
  assign result_valid_o = strobe_q;
  assign record_kind_o  = kind_q;
  assign pin_x_out_o    = out_pin_q.x;
  assign pin_y_out_o    = out_pin_q.y;
  assign last_record_o  = last_q;

endmodule

// ===== verif/ordered_pin_list_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered pin list checker
// Watches the request and result channels of the pin list engine, keeps a
// shadow copy of the list, predicts every dump word and compares each one
// as it appears.
// ----------------------------------------------------------------------------
module ordered_pin_list_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic                       req_type_i,
  input  logic [opl_pkg::CmdW-1:0]   command_code_i,
  input  logic [opl_pkg::PosW-1:0]   position_i,
  input  logic [opl_pkg::CoordW-1:0] pin_x_in_i,
  input  logic [opl_pkg::CoordW-1:0] pin_y_in_i,
  input  logic                       result_valid_i,
  input  logic                       record_kind_i,
  input  logic [opl_pkg::CoordW-1:0] pin_x_out_i,
  input  logic [opl_pkg::CoordW-1:0] pin_y_out_i,
  input  logic                       last_record_i,
  output int                         mismatch_count_o,
  output int                         pending_o,
  output int                         pin_count_o
);
  import opl_pkg::*;

  typedef struct packed {
    logic kind;
    pin_t pin;
    logic last;
  } dump_word_t;

  pin_t       shadow_pins[MaxPins];
  int         shadow_count = 0;
  int         mismatches = 0;
  int         words_due = 0;
  dump_word_t dump_words_due[$];

  assign mismatch_count_o = mismatches;
  assign pending_o        = words_due;
  assign pin_count_o      = shadow_count;

  function automatic void apply_edit(logic [CmdW-1:0] cmd, logic [PosW-1:0] pos, pin_t pin);
    int slot;
    slot = int'(pos);
    case (cmd)
      CmdAppend, CmdInsert: begin
        // A full list drops the pin; an insert past the end becomes an append.
        if (shadow_count < MaxPins) begin
          if (cmd == CmdAppend || slot > shadow_count) slot = shadow_count;
          for (int i = shadow_count; i > slot; i--) shadow_pins[i] = shadow_pins[i-1];
          shadow_pins[slot] = pin;
          shadow_count++;
        end
      end
      CmdMove: begin
        if (slot < shadow_count) shadow_pins[slot] = pin;
      end
      CmdDelete: begin
        if (slot < shadow_count) begin
          for (int i = slot; i + 1 < shadow_count; i++) shadow_pins[i] = shadow_pins[i+1];
          shadow_count--;
        end
      end
      CmdClear: shadow_count = 0;
      default: ;
    endcase
  endfunction

  function automatic void queue_dump();
    dump_word_t word;
    word.kind = 1'b0;
    word.pin  = '0;
    word.last = (shadow_count == 0);
    dump_words_due.push_back(word);
    for (int i = 0; i < shadow_count; i++) begin
      word.kind = 1'b1;
      word.pin  = shadow_pins[i];
      word.last = (i + 1 == shadow_count);
      dump_words_due.push_back(word);
    end
  endfunction

  function automatic void check_word();
    dump_word_t want;
    if (dump_words_due.size() == 0) begin
      $error("unexpected dump word: kind %0d x %h y %h last %0d",
             record_kind_i, pin_x_out_i, pin_y_out_i, last_record_i);
      mismatches++;
    end else begin
      want = dump_words_due.pop_front();
      if (record_kind_i !== want.kind) begin
        $error("record_kind: expected %0d, got %0d", want.kind, record_kind_i);
        mismatches++;
      end
      if (pin_x_out_i !== want.pin.x) begin
        $error("pin_x_out: expected %h, got %h", want.pin.x, pin_x_out_i);
        mismatches++;
      end
      if (pin_y_out_i !== want.pin.y) begin
        $error("pin_y_out: expected %h, got %h", want.pin.y, pin_y_out_i);
        mismatches++;
      end
      if (last_record_i !== want.last) begin
        $error("last_record: expected %0d, got %0d", want.last, last_record_i);
        mismatches++;
      end
    end
  endfunction

  // A word leaving the engine is compared before a newly accepted request is
  // applied, so the two may share a clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_count = 0;
      dump_words_due.delete();
    end else begin
      if (result_valid_i === 1'b1) check_word();
      if (start_i && !busy_i) begin
        if (req_type_i) queue_dump();
        else apply_edit(command_code_i, position_i, '{x: pin_x_in_i, y: pin_y_in_i});
      end
    end
    words_due = dump_words_due.size();
  end

endmodule

// ===== verif/ordered_pin_list_engine_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered pin list engine testbench
// Drives directed and random edit and dump words into the engine with random
// gaps; a checker beside the engine predicts and compares every dump word.
// ----------------------------------------------------------------------------
module ordered_pin_list_engine_test;
  import opl_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              req_type = 1'b0;
  logic [CmdW-1:0]   command_code = '0;
  logic [PosW-1:0]   position = '0;
  logic [CoordW-1:0] pin_x_in = '0;
  logic [CoordW-1:0] pin_y_in = '0;
  logic              result_valid;
  logic              record_kind;
  logic [CoordW-1:0] pin_x_out;
  logic [CoordW-1:0] pin_y_out;
  logic              last_record;
  int                mismatch_count;
  int                words_pending;
  int                list_length;
  bit                burst = 1'b0;
  bit                growing = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ordered_pin_list_engine dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .req_type_i     (req_type),
    .command_code_i (command_code),
    .position_i     (position),
    .pin_x_in_i     (pin_x_in),
    .pin_y_in_i     (pin_y_in),
    .result_valid_o (result_valid),
    .record_kind_o  (record_kind),
    .pin_x_out_o    (pin_x_out),
    .pin_y_out_o    (pin_y_out),
    .last_record_o  (last_record)
  );

  ordered_pin_list_checker pin_list_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .req_type_i       (req_type),
    .command_code_i   (command_code),
    .position_i       (position),
    .pin_x_in_i       (pin_x_in),
    .pin_y_in_i       (pin_y_in),
    .result_valid_i   (result_valid),
    .record_kind_i    (record_kind),
    .pin_x_out_i      (pin_x_out),
    .pin_y_out_i      (pin_y_out),
    .last_record_i    (last_record),
    .mismatch_count_o (mismatch_count),
    .pending_o        (words_pending),
    .pin_count_o      (list_length)
  );

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_word(logic dump, logic [CmdW-1:0] cmd, logic [PosW-1:0] pos,
                            logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    req_type     <= dump;
    command_code <= cmd;
    position     <= pos;
    pin_x_in     <= x;
    pin_y_in     <= y;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic issue_edit(logic [CmdW-1:0] cmd, logic [PosW-1:0] pos,
                            logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    issue_word(1'b0, cmd, pos, x, y);
  endtask

  task automatic issue_dump();
    issue_word(1'b1, CmdW'($urandom), PosW'($urandom), CoordW'($urandom), CoordW'($urandom));
  endtask

  // Mostly a position inside the list, now and then anything at all.
  function automatic logic [PosW-1:0] pick_position(bit for_insert);
    int limit;
    limit = for_insert ? list_length : list_length - 1;
    if (limit < 0 || $urandom_range(0, 99) < 15) return PosW'($urandom_range(0, 255));
    return PosW'($urandom_range(0, limit));
  endfunction

  task automatic issue_random_edit();
    int               roll;
    logic [CmdW-1:0]  cmd;
    roll = $urandom_range(0, 99);
    if (growing) begin
      if (roll < 40) cmd = CmdAppend;
      else if (roll < 70) cmd = CmdInsert;
      else if (roll < 85) cmd = CmdMove;
      else cmd = CmdDelete;
    end else begin
      if (roll < 60) cmd = CmdDelete;
      else if (roll < 75) cmd = CmdMove;
      else if (roll < 90) cmd = CmdInsert;
      else cmd = CmdAppend;
    end
    issue_edit(cmd, pick_position(cmd == CmdInsert), CoordW'($urandom), CoordW'($urandom));
  endtask

  initial begin
    int roll;
    int waited;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words: empty dump, unknown commands, edits on an empty list,
    // coordinate extremes, front and past-the-end inserts, ignored moves and
    // deletes, and a clear.
    issue_dump();
    issue_edit(8'd0, 8'd0, 16'h0000, 16'h0000);
    issue_edit(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    issue_edit(CmdMove, 8'd0, 16'h1111, 16'h2222);
    issue_edit(CmdDelete, 8'd0, 16'h0000, 16'h0000);
    issue_edit(CmdAppend, 8'd0, 16'h0000, 16'h0000);
    issue_edit(CmdAppend, 8'hFF, 16'hFFFF, 16'hFFFF);
    issue_edit(CmdInsert, 8'd0, 16'h1234, 16'hABCD);
    issue_edit(CmdInsert, 8'hFF, 16'h5555, 16'hAAAA);
    issue_edit(CmdInsert, 8'd2, 16'hAAAA, 16'h5555);
    issue_dump();
    issue_edit(CmdMove, 8'd0, 16'h8001, 16'h7FFE);
    issue_edit(CmdMove, 8'hFF, 16'hDEAD, 16'hBEEF);
    issue_edit(CmdMove, 8'd5, 16'hDEAD, 16'hBEEF);
    issue_edit(CmdDelete, 8'hFF, 16'h0000, 16'h0000);
    issue_edit(CmdDelete, 8'd0, 16'h0000, 16'h0000);
    issue_edit(CmdDelete, 8'd3, 16'h0000, 16'h0000);
    issue_dump();
    issue_edit(CmdClear, 8'h80, 16'hFFFF, 16'h0000);
    issue_dump();

    // Random words. The list is grown until full, where further appends and
    // inserts are dropped, and then worn down again.
    for (int n = 0; n < 200; n++) begin
      if (n % 16 == 0) burst = ($urandom_range(0, 3) == 0);
      if (growing && list_length == MaxPins && $urandom_range(0, 3) == 0) growing = 1'b0;
      else if (!growing && (list_length == 0 || $urandom_range(0, 19) == 0)) growing = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 16) issue_dump();
      else if (roll < 20) issue_edit(CmdW'($urandom), PosW'($urandom),
                                     CoordW'($urandom), CoordW'($urandom));
      else if (roll < 22) issue_edit(CmdClear, PosW'($urandom), CoordW'($urandom),
                                     CoordW'($urandom));
      else issue_random_edit();
    end
    start <= 1'b0;

    waited = 0;
    while (words_pending != 0 && waited < 400) begin
      @(negedge clk);
      waited++;
    end
    repeat (40) @(negedge clk);

    if (mismatch_count == 0 && words_pending == 0) begin
      $display("** ordered_pin_list_engine: PASSED **");
    end else begin
      $display("** ordered_pin_list_engine: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** ordered_pin_list_engine: FAILED **");
    $finish;
  end

endmodule
